/* rtl/tritab_pkg.sv */
// Shared constants, codes and types of the triangle index table search block.
`timescale 1ns / 1ps

package tritab_pkg;

    // Default sizes handed to the top level.
    localparam int DEPTH_DEF     = 256;
    localparam int NODE_BITS_DEF = 16;

    // Fixed field widths on the stream ports.
    localparam int NODE_IN_W = 16;
    localparam int SLOT_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int USED_W    = 9;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 24;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_FIND   = 1'b1
    } command_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 2'd0,
        STS_NOT_FOUND = 2'd1,
        STS_FULL      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_RESP
    } state_t;

endpackage

/* rtl/tritab_cell.sv */
// One cell of the search chain: holds one stored triangle and checks the passing query.
`timescale 1ns / 1ps

module tritab_cell #(
    parameter int NODE_BITS = tritab_pkg::NODE_BITS_DEF,
    parameter int SLOT_BITS = 8,
    parameter int CNT_BITS  = 9,
    parameter int IDX       = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [SLOT_BITS-1:0] wr_idx,
    input  logic [NODE_BITS-1:0] wr_a,
    input  logic [NODE_BITS-1:0] wr_b,
    input  logic [NODE_BITS-1:0] wr_c,
    input  logic [CNT_BITS-1:0]  count,
    input  logic                 in_valid,
    input  logic                 in_found,
    input  logic [SLOT_BITS-1:0] in_slot,
    input  logic [NODE_BITS-1:0] in_a,
    input  logic [NODE_BITS-1:0] in_b,
    input  logic [NODE_BITS-1:0] in_c,
    output logic                 out_valid,
    output logic                 out_found,
    output logic [SLOT_BITS-1:0] out_slot,
    output logic [NODE_BITS-1:0] out_a,
    output logic [NODE_BITS-1:0] out_b,
    output logic [NODE_BITS-1:0] out_c
);

    logic [NODE_BITS-1:0] e0_reg;
    logic [NODE_BITS-1:0] e1_reg;
    logic [NODE_BITS-1:0] e2_reg;
    logic                 valid_reg;
    logic                 found_reg;
    logic                 found_next;
    logic [SLOT_BITS-1:0] slot_reg;
    logic [SLOT_BITS-1:0] slot_next;
    logic [NODE_BITS-1:0] a_reg;
    logic [NODE_BITS-1:0] b_reg;
    logic [NODE_BITS-1:0] c_reg;
    logic                 in_use;
    logic                 hit;

    // The entry holds x first and y, z behind it in either order.
    function automatic logic holds(input logic [NODE_BITS-1:0] x,
                                   input logic [NODE_BITS-1:0] y,
                                   input logic [NODE_BITS-1:0] z,
                                   input logic [NODE_BITS-1:0] e0,
                                   input logic [NODE_BITS-1:0] e1,
                                   input logic [NODE_BITS-1:0] e2);
        holds = (e0 == x) && (((e1 == y) && (e2 == z)) || ((e1 == z) && (e2 == y)));
    endfunction

    assign in_use = (count > CNT_BITS'(IDX));
    assign hit = in_use &&
                 (holds(in_a, in_b, in_c, e0_reg, e1_reg, e2_reg) ||
                  holds(in_c, in_a, in_b, e0_reg, e1_reg, e2_reg) ||
                  holds(in_b, in_c, in_a, e0_reg, e1_reg, e2_reg));

    always_comb
    begin
        found_next = in_found;
        slot_next  = in_slot;
        if (!in_found && hit)
        begin
            found_next = 1'b1;
            slot_next  = SLOT_BITS'(IDX);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_idx == SLOT_BITS'(IDX)))
        begin
            e0_reg <= wr_a;
            e1_reg <= wr_b;
            e2_reg <= wr_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
        slot_reg  <= slot_next;
        a_reg     <= in_a;
        b_reg     <= in_b;
        c_reg     <= in_c;
    end

    assign out_valid = valid_reg;
    assign out_found = found_reg;
    assign out_slot  = slot_reg;
    assign out_a     = a_reg;
    assign out_b     = b_reg;
    assign out_c     = c_reg;

endmodule

/* rtl/triangle_index_table_search_top.sv */
// Top level of the triangle index table search block: control, count and the cell chain.
`timescale 1ns / 1ps

// Channel   Direction  Accepted when                   Contents
// s_axis    in         s_axis_tvalid && s_axis_tready  tuser: command; tdata: node_a, b, c
// m_axis    out        m_axis_tvalid && m_axis_tready  tdata: slot, status, entries_used
//
// An insert writes the cell selected by the count directly; its result is registered and
// then loaded into the output register in ST_RESP; the next item is taken in ST_IDLE.
// A find walks the chain one cell per cycle; its result is registered from the last cell,
// then loaded into the output register in ST_RESP; the next item is taken in ST_IDLE.
// One item is in work at a time; a new item is taken while a result still waits, and a
// finished item holds off the input until the output register is free.
// Reset clears the count, the chain's valid bits and the output valid.

module triangle_index_table_search_top #(
    parameter int DEPTH     = tritab_pkg::DEPTH_DEF,
    parameter int NODE_BITS = tritab_pkg::NODE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // Bits from low: node_a[15:0], node_b[31:16], node_c[47:32].
    input  logic [tritab_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // Bits from low: command[0].
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // Bits from low: slot[7:0], status[9:8], entries_used[18:10], zeros above.
    output logic [tritab_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int SLOT_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS  = $clog2(DEPTH + 1);
    localparam int NW        = tritab_pkg::NODE_IN_W;
    localparam int SW        = tritab_pkg::SLOT_W;
    localparam int UW        = tritab_pkg::USED_W;

    tritab_pkg::state_t   state_reg;
    tritab_pkg::state_t   state_next;
    tritab_pkg::command_t cmd;

    logic                 in_acc;
    logic                 out_free;
    logic                 load_out;
    logic                 full;
    logic                 wr_en;
    logic [CNT_BITS-1:0]  count_reg;
    logic [CNT_BITS-1:0]  count_next;

    logic [NODE_BITS+NW-1:0] ext_a;
    logic [NODE_BITS+NW-1:0] ext_b;
    logic [NODE_BITS+NW-1:0] ext_c;
    logic [NODE_BITS-1:0]    node_a;
    logic [NODE_BITS-1:0]    node_b;
    logic [NODE_BITS-1:0]    node_c;

    logic [DEPTH:0]          tok_valid;
    logic [DEPTH:0]          tok_found;
    logic [SLOT_BITS-1:0]    tok_slot [0:DEPTH];
    logic [NODE_BITS-1:0]    tok_a [0:DEPTH];
    logic [NODE_BITS-1:0]    tok_b [0:DEPTH];
    logic [NODE_BITS-1:0]    tok_c [0:DEPTH];

    logic [SLOT_BITS-1:0]    res_slot_reg;
    tritab_pkg::status_t     res_status_reg;
    logic [CNT_BITS-1:0]     res_used_reg;
    logic [SLOT_BITS+SW-1:0] slot_ext;
    logic [CNT_BITS+UW-1:0]  used_ext;

    logic                    m_valid_reg;
    logic [SW-1:0]           m_slot_reg;
    tritab_pkg::status_t     m_status_reg;
    logic [UW-1:0]           m_used_reg;

    assign cmd      = tritab_pkg::command_t'(s_axis_tuser);
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_valid_reg || m_axis_tready;
    assign full     = (count_reg == CNT_BITS'(DEPTH));
    assign wr_en    = in_acc && (cmd == tritab_pkg::CMD_INSERT) && !full;

    // Input bits above NODE_BITS are dropped; narrower inputs are zero extended.
    assign ext_a  = {{NODE_BITS{1'b0}}, s_axis_tdata[NW-1:0]};
    assign ext_b  = {{NODE_BITS{1'b0}}, s_axis_tdata[2*NW-1:NW]};
    assign ext_c  = {{NODE_BITS{1'b0}}, s_axis_tdata[3*NW-1:2*NW]};
    assign node_a = ext_a[NODE_BITS-1:0];
    assign node_b = ext_b[NODE_BITS-1:0];
    assign node_c = ext_c[NODE_BITS-1:0];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tritab_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = (cmd == tritab_pkg::CMD_INSERT) ? tritab_pkg::ST_RESP
                                                                 : tritab_pkg::ST_SEARCH;
                end
            end
            tritab_pkg::ST_SEARCH:
            begin
                if (tok_valid[DEPTH])
                begin
                    state_next = tritab_pkg::ST_RESP;
                end
            end
            tritab_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = tritab_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tritab_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        s_axis_tready = 1'b0;
        load_out      = 1'b0;
        unique case (state_reg)
            tritab_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            tritab_pkg::ST_SEARCH:
            begin
                s_axis_tready = 1'b0;
            end
            tritab_pkg::ST_RESP:
            begin
                load_out = out_free;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tritab_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign count_next = wr_en ? (count_reg + CNT_BITS'(1)) : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Query token enters the chain at cell zero.
    assign tok_valid[0] = in_acc && (cmd == tritab_pkg::CMD_FIND);
    assign tok_found[0] = 1'b0;
    assign tok_slot[0]  = '0;
    assign tok_a[0]     = node_a;
    assign tok_b[0]     = node_b;
    assign tok_c[0]     = node_c;

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        tritab_cell #(
            .NODE_BITS (NODE_BITS),
            .SLOT_BITS (SLOT_BITS),
            .CNT_BITS  (CNT_BITS),
            .IDX       (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .wr_en     (wr_en),
            .wr_idx    (count_reg[SLOT_BITS-1:0]),
            .wr_a      (node_a),
            .wr_b      (node_b),
            .wr_c      (node_c),
            .count     (count_reg),
            .in_valid  (tok_valid[k]),
            .in_found  (tok_found[k]),
            .in_slot   (tok_slot[k]),
            .in_a      (tok_a[k]),
            .in_b      (tok_b[k]),
            .in_c      (tok_c[k]),
            .out_valid (tok_valid[k+1]),
            .out_found (tok_found[k+1]),
            .out_slot  (tok_slot[k+1]),
            .out_a     (tok_a[k+1]),
            .out_b     (tok_b[k+1]),
            .out_c     (tok_c[k+1])
        );
    end

    // Pending result of the item in work.
    always_ff @(posedge clk)
    begin
        if (in_acc && (cmd == tritab_pkg::CMD_INSERT))
        begin
            res_slot_reg   <= full ? '0 : count_reg[SLOT_BITS-1:0];
            res_status_reg <= full ? tritab_pkg::STS_FULL : tritab_pkg::STS_OK;
            res_used_reg   <= count_next;
        end
        else if (tok_valid[DEPTH])
        begin
            res_slot_reg   <= tok_found[DEPTH] ? tok_slot[DEPTH] : '0;
            res_status_reg <= tok_found[DEPTH] ? tritab_pkg::STS_OK
                                               : tritab_pkg::STS_NOT_FOUND;
            res_used_reg   <= count_reg;
        end
    end

    assign slot_ext = {{SW{1'b0}}, res_slot_reg};
    assign used_ext = {{UW{1'b0}}, res_used_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            m_slot_reg   <= slot_ext[SW-1:0];
            m_status_reg <= res_status_reg;
            m_used_reg   <= used_ext[UW-1:0];
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(tritab_pkg::OUT_DATA_W - SW - tritab_pkg::STATUS_W - UW){1'b0}},
                            m_used_reg, m_status_reg, m_slot_reg};

    // At most one query travels the chain.
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(tok_valid))
        else $error("more than one query token in the chain");

    // A query leaves the chain only while a search is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
                     tok_valid[DEPTH] |-> (state_reg == tritab_pkg::ST_SEARCH))
        else $error("query token left the chain outside a search");

    // The count never runs past the table depth.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_BITS'(DEPTH))
        else $error("entry count exceeds depth");

    // An accepted item always moves the controller out of idle.
    assert property (@(posedge clk) disable iff (!rst_n)
                     in_acc |=> (state_reg != tritab_pkg::ST_IDLE))
        else $error("accepted item did not start work");

endmodule
